// ----- hw/rtl/pwbt_pkg.sv -----
package pwbt_pkg;

	// Frame store depth, fixed by the 3-bit byte index.
	localparam int unsigned STORE_DEPTH = 8;
	localparam int unsigned STORE_AW    = 3;
	localparam int unsigned BPTR_W      = 4;   // byte pointer must reach STORE_DEPTH
	localparam int unsigned TICK_W      = 10;

	localparam logic [TICK_W-1:0] TICK_MAX = 10'd1023;
	localparam logic [BPTR_W-1:0] STORE_DEPTH_C = 4'd8;

	// Actions carried by an input word.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_IDLE_TICKS  = 3'd0;
	localparam logic [2:0] REG_DRIVE_END   = 3'd1;
	localparam logic [2:0] REG_RELEASE_END = 3'd2;
	localparam logic [2:0] REG_ZERO_END    = 3'd3;
	localparam logic [2:0] REG_ONE_END     = 3'd4;
	localparam logic [2:0] REG_FRAME_BYTES = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_WAIT    = 3'd1,
		PH_START   = 3'd2,
		PH_DRIVE   = 3'd3,
		PH_BLANK   = 3'd4,
		PH_MONITOR = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE      = 2'd0,
		CAUSE_BUSY      = 2'd1,
		CAUSE_COLLISION = 2'd2
	} cause_t;

	typedef struct packed {
		logic [9:0] idle_ticks;
		logic [9:0] drive_end;
		logic [9:0] release_end;
		logic [9:0] zero_end;
		logic [9:0] one_end;
		logic [3:0] frame_bytes;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] byte_index;
		logic [7:0] byte_value;
		logic       bus_released;
	} item_t;

	typedef struct packed {
		logic   bus_drive;
		logic   busy_res;
		logic   done_res;
		logic   success;
		cause_t fail_cause;
	} result_t;

endpackage

// ----- hw/rtl/pwbt_in_if.sv -----
interface pwbt_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] byte_index;
	logic [7:0] byte_value;
	logic       bus_released;

	modport source(output valid, action, byte_index, byte_value, bus_released, input ready);
	modport sink(input valid, action, byte_index, byte_value, bus_released, output ready);
endinterface

// ----- hw/rtl/pwbt_out_if.sv -----
interface pwbt_out_if;
	logic       valid;
	logic       ready;
	logic       bus_drive;
	logic       busy_res;
	logic       done_res;
	logic       success;
	logic [1:0] fail_cause;

	modport source(output valid, bus_drive, busy_res, done_res, success, fail_cause, input ready);
	modport sink(input valid, bus_drive, busy_res, done_res, success, fail_cause, output ready);
endinterface

// ----- hw/rtl/pwbt_cfg_if.sv -----
interface pwbt_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pwbt_engine.sv -----
module pwbt_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pwbt_pkg::item_t  item,
	input  pwbt_pkg::cfg_t   cfg,
	output pwbt_pkg::result_t result
);

	pwbt_pkg::phase_t                 phase_q, phase_n;
	logic [pwbt_pkg::TICK_W-1:0]      tick_q, tick_n;
	logic [pwbt_pkg::BPTR_W-1:0]      bptr_q, bptr_n;
	logic [2:0]                       bitp_q, bitp_n;
	logic                             cur_q, cur_n;
	logic                             stop_q, stop_n;
	logic [7:0]                       store_q [pwbt_pkg::STORE_DEPTH];

	logic                             done;
	logic                             ok;
	pwbt_pkg::cause_t                 cause;
	logic [pwbt_pkg::BPTR_W-1:0]      nbytes;

	// Bytes per frame, saturated to the store depth.
	assign nbytes = (cfg.frame_bytes > pwbt_pkg::STORE_DEPTH_C) ?
		pwbt_pkg::STORE_DEPTH_C : cfg.frame_bytes;

	// Next state
	always_comb begin
		logic [pwbt_pkg::TICK_W-1:0] t;
		logic [pwbt_pkg::TICK_W-1:0] slot_end;
		logic [7:0]                  sel_byte;
		pwbt_pkg::phase_t            p;
		logic                        pick;
		logic [pwbt_pkg::BPTR_W-1:0] pb;
		logic [2:0]                  pbit;

		phase_n  = phase_q;
		tick_n   = tick_q;
		bptr_n   = bptr_q;
		bitp_n   = bitp_q;
		cur_n    = cur_q;
		stop_n   = stop_q;
		done     = 1'b0;
		ok       = 1'b0;
		cause    = pwbt_pkg::CAUSE_NONE;
		pick     = 1'b0;
		pb       = bptr_q;
		pbit     = bitp_q;
		p        = phase_q;
		t        = (tick_q < pwbt_pkg::TICK_MAX) ? tick_q + 10'd1 : tick_q;
		slot_end = cur_q ? cfg.one_end : cfg.zero_end;

		case (item.action)
			pwbt_pkg::ACT_START: begin
				if (phase_q == pwbt_pkg::PH_IDLE) begin
					phase_n = pwbt_pkg::PH_WAIT;
					tick_n  = '0;
					bptr_n  = '0;
					bitp_n  = '0;
					cur_n   = 1'b0;
					stop_n  = 1'b0;
				end
			end
			pwbt_pkg::ACT_TICK: begin
				if (phase_q == pwbt_pkg::PH_WAIT) begin
					if (!item.bus_released) begin
						done  = 1'b1;
						cause = pwbt_pkg::CAUSE_BUSY;
					end else begin
						tick_n = t;
						if (t >= cfg.idle_ticks) begin
							phase_n = pwbt_pkg::PH_START;
							pick    = 1'b1;
						end
					end
				end else if (phase_q == pwbt_pkg::PH_START) begin
					if (!item.bus_released) begin
						done  = 1'b1;
						cause = pwbt_pkg::CAUSE_BUSY;
					end else begin
						tick_n  = '0;
						phase_n = pwbt_pkg::PH_DRIVE;
					end
				end else if (phase_q != pwbt_pkg::PH_IDLE) begin
					tick_n = t;
					// Limits are checked in order on the same tick.
					if (p == pwbt_pkg::PH_DRIVE && t >= cfg.drive_end)
						p = pwbt_pkg::PH_BLANK;
					if (p == pwbt_pkg::PH_BLANK && t >= cfg.release_end)
						p = pwbt_pkg::PH_MONITOR;
					if (p == pwbt_pkg::PH_MONITOR) begin
						if (t >= slot_end) begin
							if (stop_q) begin
								done = 1'b1;
								ok   = 1'b1;
							end else begin
								pbit = bitp_q + 3'd1;
								if (bitp_q == 3'd7)
									pb = bptr_q + 4'd1;
								bitp_n = pbit;
								bptr_n = pb;
								pick   = 1'b1;
								p      = pwbt_pkg::PH_START;
							end
						end else if (!item.bus_released) begin
							done  = 1'b1;
							cause = pwbt_pkg::CAUSE_COLLISION;
						end
					end
					phase_n = p;
				end
			end
			default: begin
			end
		endcase

		// Choose the next bit: past the frame it is the closing 1.
		sel_byte = store_q[pb[pwbt_pkg::STORE_AW-1:0]];
		if (pick) begin
			if (pb >= nbytes) begin
				stop_n = 1'b1;
				cur_n  = 1'b1;
			end else begin
				cur_n = sel_byte[3'd7 - pbit];
			end
		end

		if (done) begin
			phase_n = pwbt_pkg::PH_IDLE;
			tick_n  = '0;
		end
	end

	// Outputs
	always_comb begin
		result.bus_drive  = (phase_n == pwbt_pkg::PH_DRIVE);
		result.busy_res   = (phase_n != pwbt_pkg::PH_IDLE);
		result.done_res   = done;
		result.success    = done & ok;
		result.fail_cause = done ? cause : pwbt_pkg::CAUSE_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pwbt_pkg::PH_IDLE;
			tick_q  <= '0;
			bptr_q  <= '0;
			bitp_q  <= '0;
			cur_q   <= 1'b0;
			stop_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bptr_q  <= bptr_n;
			bitp_q  <= bitp_n;
			cur_q   <= cur_n;
			stop_q  <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item.action == pwbt_pkg::ACT_LOAD)
			store_q[item.byte_index] <= item.byte_value;
	end

endmodule

// ----- hw/rtl/pulse_width_bus_transmitter_unit.sv -----
// A word's result is registered when the engine steps on it. Throughput: one word
// per cycle while the output is taken; input register and result register each
// hold one word, so a stalled output backs up into the input after two words.
// Reset (arst_n low, asynchronous): send state idle, pipeline empty, registers at
// their defaults; frame store contents are undefined until loaded.
module pulse_width_bus_transmitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	pwbt_in_if.sink     in_ch,
	pwbt_out_if.source  out_ch,
	pwbt_cfg_if.sink    cfg_ch
);

	// Input stage: hold the accepted word until the engine can step on it.
	pwbt_pkg::item_t   item_s1;
	logic              valid_s1;

	// Result stage: hold the result until the sink takes it.
	pwbt_pkg::result_t res_s2;
	logic              valid_s2;

	pwbt_pkg::cfg_t    cfg_q;
	pwbt_pkg::result_t res_next;
	logic              advance;
	logic              step;

	// Advance the input word into the result stage when the result slot is free
	// or being drained in the same cycle.
	assign advance     = !valid_s2 || out_ch.ready;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	// User must write configuration while idle (not enforced); accept at once.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.action       <= in_ch.action;
			item_s1.byte_index   <= in_ch.byte_index;
			item_s1.byte_value   <= in_ch.byte_value;
			item_s1.bus_released <= in_ch.bus_released;
		end
	end

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_ticks  <= 10'd512;
			cfg_q.drive_end   <= 10'd40;
			cfg_q.release_end <= 10'd80;
			cfg_q.zero_end    <= 10'd98;
			cfg_q.one_end     <= 10'd236;
			cfg_q.frame_bytes <= 4'd5;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				pwbt_pkg::REG_IDLE_TICKS:  cfg_q.idle_ticks  <= cfg_ch.data;
				pwbt_pkg::REG_DRIVE_END:   cfg_q.drive_end   <= cfg_ch.data;
				pwbt_pkg::REG_RELEASE_END: cfg_q.release_end <= cfg_ch.data;
				pwbt_pkg::REG_ZERO_END:    cfg_q.zero_end    <= cfg_ch.data;
				pwbt_pkg::REG_ONE_END:     cfg_q.one_end     <= cfg_ch.data;
				pwbt_pkg::REG_FRAME_BYTES: cfg_q.frame_bytes <= cfg_ch.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Bit timing, frame store and send state; one step per word.
	pwbt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_next;
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.bus_drive  = res_s2.bus_drive;
	assign out_ch.busy_res   = res_s2.busy_res;
	assign out_ch.done_res   = res_s2.done_res;
	assign out_ch.success    = res_s2.success;
	assign out_ch.fail_cause = res_s2.fail_cause;

endmodule

// ----- tb/pulse_width_bus_transmitter_unit_tb.sv -----
`timescale 1ns / 1ps

module pulse_width_bus_transmitter_unit_tb;

	// Action and register codes that the block ignores but the fields allow.
	localparam logic [1:0] ACT_SPARE    = 2'd3;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// Register values after reset.
	localparam pwbt_pkg::cfg_t CFG_AT_RESET = '{
		idle_ticks: 10'd512, drive_end: 10'd40, release_end: 10'd80,
		zero_end: 10'd98, one_end: 10'd236, frame_bytes: 4'd5
	};

	// Each result passes the input and result registers; settle past the last status.
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pwbt_in_if  in_ch();
	pwbt_out_if out_ch();
	pwbt_cfg_if cfg_ch();

	pulse_width_bus_transmitter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 0;
	end

	// ------------------------------------------------------------------
	// Transmitter shadow: register copy and send state, advanced once per
	// word taken by the block.
	// ------------------------------------------------------------------
	pwbt_pkg::cfg_t                 shadow_cfg = CFG_AT_RESET;
	pwbt_pkg::phase_t               send_phase = pwbt_pkg::PH_IDLE;
	logic [pwbt_pkg::TICK_W-1:0]    slot_ticks = '0;
	logic [7:0]                     frame_copy [pwbt_pkg::STORE_DEPTH];
	logic [pwbt_pkg::BPTR_W-1:0]    byte_ptr = '0;
	logic [2:0]                     bit_ptr = '0;
	logic                           bit_now = 1'b0;
	logic                           closing_bit = 1'b0;

	pwbt_pkg::item_t   pending_words [$];
	pwbt_pkg::result_t expected_status [$];
	int      words_queued = 0;
	int      words_taken = 0;
	int      statuses_seen = 0;
	int      error_count = 0;

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns, status %0d: %s", $time, statuses_seen, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Pick the next bit: the stored bit, or the closing 1 once the frame is out.
	task automatic pick_bit();
		logic [pwbt_pkg::BPTR_W-1:0] frame_len;
		frame_len = (shadow_cfg.frame_bytes > pwbt_pkg::STORE_DEPTH_C) ?
			pwbt_pkg::STORE_DEPTH_C : shadow_cfg.frame_bytes;
		if (byte_ptr >= frame_len || byte_ptr >= pwbt_pkg::STORE_DEPTH_C) begin
			closing_bit = 1'b1;
			bit_now = 1'b1;
		end else begin
			bit_now = frame_copy[byte_ptr[pwbt_pkg::STORE_AW-1:0]][3'd7 - bit_ptr];
		end
	endtask

	task automatic bump_ticks();
		if (slot_ticks < pwbt_pkg::TICK_MAX)
			slot_ticks = slot_ticks + 1'b1;
	endtask

	task automatic predict_status(input pwbt_pkg::item_t w);
		pwbt_pkg::result_t           r;
		logic                        finished;
		logic                        sent_ok;
		pwbt_pkg::cause_t            why;
		logic [pwbt_pkg::TICK_W-1:0] slot_end;
		finished = 1'b0;
		sent_ok = 1'b0;
		why = pwbt_pkg::CAUSE_NONE;
		case (w.action)
			pwbt_pkg::ACT_LOAD: begin
				frame_copy[w.byte_index] = w.byte_value;
			end
			pwbt_pkg::ACT_START: begin
				if (send_phase == pwbt_pkg::PH_IDLE) begin
					send_phase = pwbt_pkg::PH_WAIT;
					slot_ticks = '0;
					byte_ptr = '0;
					bit_ptr = '0;
					bit_now = 1'b0;
					closing_bit = 1'b0;
				end
			end
			pwbt_pkg::ACT_TICK: begin
				if (send_phase == pwbt_pkg::PH_WAIT) begin
					if (!w.bus_released) begin
						finished = 1'b1;
						why = pwbt_pkg::CAUSE_BUSY;
					end else begin
						bump_ticks();
						if (slot_ticks >= shadow_cfg.idle_ticks) begin
							send_phase = pwbt_pkg::PH_START;
							pick_bit();
						end
					end
				end else if (send_phase == pwbt_pkg::PH_START) begin
					if (!w.bus_released) begin
						finished = 1'b1;
						why = pwbt_pkg::CAUSE_BUSY;
					end else begin
						slot_ticks = '0;
						send_phase = pwbt_pkg::PH_DRIVE;
					end
				end else if (send_phase != pwbt_pkg::PH_IDLE) begin
					// Thresholds fall through in order on the same tick.
					bump_ticks();
					if (send_phase == pwbt_pkg::PH_DRIVE &&
					    slot_ticks >= shadow_cfg.drive_end)
						send_phase = pwbt_pkg::PH_BLANK;
					if (send_phase == pwbt_pkg::PH_BLANK &&
					    slot_ticks >= shadow_cfg.release_end)
						send_phase = pwbt_pkg::PH_MONITOR;
					if (send_phase == pwbt_pkg::PH_MONITOR) begin
						slot_end = bit_now ? shadow_cfg.one_end : shadow_cfg.zero_end;
						if (slot_ticks >= slot_end) begin
							if (closing_bit) begin
								finished = 1'b1;
								sent_ok = 1'b1;
							end else begin
								if (bit_ptr == 3'd7)
									byte_ptr = byte_ptr + 1'b1;
								bit_ptr = bit_ptr + 1'b1;
								pick_bit();
								send_phase = pwbt_pkg::PH_START;
							end
						end else if (!w.bus_released) begin
							finished = 1'b1;
							why = pwbt_pkg::CAUSE_COLLISION;
						end
					end
				end
				if (finished) begin
					send_phase = pwbt_pkg::PH_IDLE;
					slot_ticks = '0;
				end
			end
			default: ;
		endcase
		r.bus_drive = (send_phase == pwbt_pkg::PH_DRIVE);
		r.busy_res = (send_phase != pwbt_pkg::PH_IDLE);
		r.done_res = finished;
		r.success = finished && sent_ok;
		r.fail_cause = finished ? why : pwbt_pkg::CAUSE_NONE;
		expected_status.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Input driver: bursts of random length, random gaps between them.
	// A word on the bus holds until the block takes it.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : drive_words
		logic            taken;
		logic            offer;
		pwbt_pkg::item_t w;
		if (arst_n) begin
			taken = in_ch.valid && in_ch.ready;
			if (taken) begin
				predict_status(pwbt_pkg::item_t'({in_ch.action, in_ch.byte_index,
				                                  in_ch.byte_value, in_ch.bus_released}));
				words_taken++;
			end
			// Hold a word that was not taken; otherwise pick the next one.
			if (!in_ch.valid || taken) begin
				offer = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					offer = 1'b1;
					in_ch.action <= w.action;
					in_ch.byte_index <= w.byte_index;
					in_ch.byte_value <= w.byte_value;
					in_ch.bus_released <= w.bus_released;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				in_ch.valid <= offer;
			end
		end
	end

	// ------------------------------------------------------------------
	// Status monitor and receiver. Ready follows a rotating stall pattern;
	// twice in the run the receiver holds off for a long stretch so the
	// block backs up into its input.
	// ------------------------------------------------------------------
	logic [7:0] stall_pat = 8'h00;
	int         pat_age = 0;
	int         hold_left = 0;
	int         last_hold_at = -1;

	// Long hold-off at fixed points in the stream, counted in cycles.
	always @(posedge clk) begin : hold_off
		if (arst_n) begin
			if ((statuses_seen == 100 || statuses_seen == 450) && hold_left == 0
			    && last_hold_at != statuses_seen) begin
				hold_left <= HOLD_CYCLES;
				last_hold_at <= statuses_seen;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(posedge clk) begin : watch_status
		pwbt_pkg::result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				statuses_seen++;
				if (expected_status.size() == 0) begin
					report_error("status word with nothing expected");
				end else begin
					want = expected_status.pop_front();
					check_field("bus_drive", 2'(out_ch.bus_drive), 2'(want.bus_drive));
					check_field("busy_res", 2'(out_ch.busy_res), 2'(want.busy_res));
					check_field("done_res", 2'(out_ch.done_res), 2'(want.done_res));
					check_field("success", 2'(out_ch.success), 2'(want.success));
					check_field("fail_cause", out_ch.fail_cause, want.fail_cause);
				end
			end

			// Rotate the stall pattern; refresh it now and then, often to no stalls.
			pat_age++;
			if (pat_age == 64) begin
				pat_age = 0;
				stall_pat = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
			end else begin
				stall_pat = {stall_pat[0], stall_pat[7:1]};
			end
			out_ch.ready <= (hold_left == 0) && !stall_pat[0];
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and register programming.
	// ------------------------------------------------------------------
	task automatic queue_word(input logic [1:0] act, input logic [2:0] idx,
	                          input logic [7:0] value, input logic released);
		pending_words.push_back(pwbt_pkg::item_t'({act, idx, value, released}));
		words_queued++;
	endtask

	// Write one register; valid stays up so back-to-back writes need no drop.
	task automatic cfg_write(input logic [2:0] idx, input logic [9:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			pwbt_pkg::REG_IDLE_TICKS:  shadow_cfg.idle_ticks = value;
			pwbt_pkg::REG_DRIVE_END:   shadow_cfg.drive_end = value;
			pwbt_pkg::REG_RELEASE_END: shadow_cfg.release_end = value;
			pwbt_pkg::REG_ZERO_END:    shadow_cfg.zero_end = value;
			pwbt_pkg::REG_ONE_END:     shadow_cfg.one_end = value;
			pwbt_pkg::REG_FRAME_BYTES: shadow_cfg.frame_bytes = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [9:0] idle, input logic [9:0] drv,
	                          input logic [9:0] rel, input logic [9:0] zero_slot,
	                          input logic [9:0] one_slot, input logic [9:0] nbytes);
		cfg_write(pwbt_pkg::REG_IDLE_TICKS, idle);
		cfg_write(pwbt_pkg::REG_DRIVE_END, drv);
		cfg_write(pwbt_pkg::REG_RELEASE_END, rel);
		cfg_write(pwbt_pkg::REG_ZERO_END, zero_slot);
		cfg_write(pwbt_pkg::REG_ONE_END, one_slot);
		cfg_write(pwbt_pkg::REG_FRAME_BYTES, nbytes);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly ticks on a quiet bus, with starts, loads and spare actions mixed in.
	task automatic queue_random(input int count, input int noise_pct);
		int pick;
		queue_word(pwbt_pkg::ACT_START, 3'($urandom), 8'($urandom), 1'($urandom));
		for (int n = 1; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				queue_word(pwbt_pkg::ACT_START, 3'($urandom), 8'($urandom), 1'($urandom));
			else if (pick < 9)
				queue_word(pwbt_pkg::ACT_LOAD, 3'($urandom), 8'($urandom), 1'($urandom));
			else if (pick < 10)
				queue_word(ACT_SPARE, 3'($urandom), 8'($urandom), 1'($urandom));
			else
				queue_word(pwbt_pkg::ACT_TICK, 3'($urandom), 8'($urandom),
				           $urandom_range(0, 99) >= noise_pct);
		end
	endtask

	// Wait until every word is taken and every status checked.
	task automatic settle();
		while (words_taken != words_queued || expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < pwbt_pkg::STORE_DEPTH; i++)
			frame_copy[i] = 8'h00;
		in_ch.valid = 1'b0;
		in_ch.action = pwbt_pkg::ACT_TICK;
		in_ch.byte_index = '0;
		in_ch.byte_value = '0;
		in_ch.bus_released = 1'b1;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = pwbt_pkg::REG_IDLE_TICKS;
		cfg_ch.data = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the store, then walk the failure paths with a
		// closing-bit-only frame.
		set_timing(10'd2, 10'd1, 10'd2, 10'd3, 10'd4, 10'd0);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd1, 8'hFF, 1'b0);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd2, 8'hA5, 1'b1);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd3, 8'h5A, 1'b0);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd4, 8'h80, 1'b1);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd5, 8'h01, 1'b0);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd6, 8'hC3, 1'b1);
		queue_word(pwbt_pkg::ACT_LOAD, 3'd7, 8'h3C, 1'b0);
		queue_word(pwbt_pkg::ACT_TICK, 3'd7, 8'hFF, 1'b0);    // tick while idle
		queue_word(ACT_SPARE, 3'd5, 8'h55, 1'b1);             // unknown action
		queue_word(pwbt_pkg::ACT_START, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_START, 3'd0, 8'h00, 1'b1);   // start while busy
		queue_word(pwbt_pkg::ACT_LOAD, 3'd7, 8'h7E, 1'b1);    // load while busy
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b0);    // bus busy during idle wait
		queue_word(pwbt_pkg::ACT_START, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b0);    // bus busy at bit start
		queue_word(pwbt_pkg::ACT_START, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b1);
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b1);    // drive
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b0);    // blank ignores the bus
		queue_word(pwbt_pkg::ACT_TICK, 3'd0, 8'h00, 1'b0);    // collision in the slot
		settle();

		// Normal ordering of thresholds, quiet bus, one byte.
		set_timing(10'd3, 10'd2, 10'd4, 10'd6, 10'd9, 10'd1);
		queue_random(130, 0);
		settle();

		// Release before drive end and slot end before release: fall through.
		cfg_write(REG_SPARE_LO, 10'h3FF);
		cfg_write(REG_SPARE_HI, 10'h000);
		set_timing(10'd1, 10'd3, 10'd2, 10'd1, 10'd2, 10'd2);
		queue_random(130, 2);
		settle();

		// All thresholds zero; frame length above the store saturates to full.
		set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF);
		queue_random(130, 0);
		settle();

		// Largest values: the idle wait dominates.
		set_timing(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'd8);
		queue_random(100, 1);
		settle();

		// Random short timings with random frame length bits.
		repeat (2) begin
			set_timing(10'($urandom_range(0, 6)), 10'($urandom_range(0, 4)),
			           10'($urandom_range(0, 8)), 10'($urandom_range(0, 10)),
			           10'($urandom_range(0, 14)), 10'($urandom));
			queue_random(150, ($urandom_range(0, 1) == 0) ? 0 : 3);
			settle();
		end

		repeat (6) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- pulse_width_bus_transmitter_unit.f -----
hw/rtl/pwbt_pkg.sv
hw/rtl/pwbt_in_if.sv
hw/rtl/pwbt_out_if.sv
hw/rtl/pwbt_cfg_if.sv
hw/rtl/pwbt_engine.sv
hw/rtl/pulse_width_bus_transmitter_unit.sv
tb/pulse_width_bus_transmitter_unit_tb.sv
